// File: design/umepe_pkg.sv
// Shared types and constants for the USB-MIDI event packet encoder.
// No dependencies; imported by every module of the block.
package umepe_pkg;

  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_PROGRAM  = 3'd4;
  localparam logic [2:0] KIND_PRESSURE = 3'd5;
  localparam logic [2:0] KIND_BEND     = 3'd6;
  localparam logic [2:0] KIND_SYSEX    = 3'd7;

  localparam logic [3:0]  CIN_SYSEX_CONT = 4'h4;
  localparam logic [3:0]  CABLE_NUM      = 4'h0;
  localparam logic [13:0] BEND_OFFSET    = 14'd8192;
  localparam logic [7:0]  DATA_MASK      = 8'h7F;
  localparam logic [1:0]  SYSEX_HOLD_MAX = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic        is_sysex;
    logic [2:0]  kind;
    logic [3:0]  chan;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [13:0] bend;
    logic [3:0]  cin;
  } pkt_cmd_t;

  typedef struct packed {
    logic       link;
    logic [1:0] held_cnt;
  } fe_status_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

endpackage

// File: design/umepe_front.sv
// Front end: accepts items, holds the link flag, gathers sysex bytes and
// issues packet commands to the queue. Depends on umepe_pkg.
module umepe_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_req_type,
  input  logic [3:0]            in_channel,
  input  logic [7:0]            in_data_first,
  input  logic [7:0]            in_data_second,
  input  logic signed [13:0]    in_bend_amount,
  input  logic                  in_sysex_end,
  output logic                  push_valid,
  input  logic                  push_ready,
  output umepe_pkg::pkt_cmd_t   push_cmd,
  output umepe_pkg::fe_status_t status
);
  import umepe_pkg::*;

  logic       link_r;
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [7:0] held_r [2];
  logic       take;
  logic       is_sysex;
  logic       hold_byte;

  assign in_ready  = !link_r || push_ready;
  assign take      = in_valid && in_ready && link_r;
  assign is_sysex  = (in_req_type == KIND_SYSEX);
  assign hold_byte = is_sysex && !in_sysex_end && (held_cnt_r < SYSEX_HOLD_MAX);

  always_comb begin
    push_cmd          = '0;
    push_cmd.is_sysex = is_sysex;
    push_cmd.kind     = in_req_type;
    push_cmd.chan     = in_channel;
    push_cmd.bend     = $unsigned(in_bend_amount);
    push_cmd.cin      = CIN_SYSEX_CONT;
    if (is_sysex) begin
      case (held_cnt_r)
        2'd0: begin
          push_cmd.b0 = in_data_first;
        end
        2'd1: begin
          push_cmd.b0 = held_r[0];
          push_cmd.b1 = in_data_first;
        end
        default: begin
          push_cmd.b0 = held_r[0];
          push_cmd.b1 = held_r[1];
          push_cmd.b2 = in_data_first;
        end
      endcase
      if (in_sysex_end) begin
        push_cmd.cin = CIN_SYSEX_CONT + {2'b00, held_cnt_r} + 4'd1;
      end
    end else begin
      push_cmd.b0 = in_data_first;
      push_cmd.b1 = in_data_second;
    end
  end

  assign push_valid = take && !hold_byte;

  always_comb begin
    held_cnt_nxt = held_cnt_r;
    if (take && is_sysex) begin
      held_cnt_nxt = hold_byte ? held_cnt_r + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r     <= 1'b0;
      held_cnt_r <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        link_r <= cfg_wr_data;
      end
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hold_byte) begin
      held_r[held_cnt_r[0]] <= in_data_first;
    end
  end

  assign status.link     = link_r;
  assign status.held_cnt = held_cnt_r;

endmodule

// File: design/umepe_queue.sv
// Short command queue between front and back ends.
// Depends on umepe_pkg.
module umepe_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  umepe_pkg::pkt_cmd_t  push_cmd,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output umepe_pkg::pkt_cmd_t  pop_cmd,
  output umepe_pkg::q_status_t status
);
  import umepe_pkg::*;

  pkt_cmd_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               push, pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign status.count = count_r;

endmodule

// File: design/umepe_back.sv
// Back end: formats queued commands into USB-MIDI event packets and holds
// them in the output register. Depends on umepe_pkg.
module umepe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  umepe_pkg::pkt_cmd_t pop_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_packet_header,
  output logic [7:0]          out_packet_byte_one,
  output logic [7:0]          out_packet_byte_two,
  output logic [7:0]          out_packet_byte_three
);
  import umepe_pkg::*;

  logic        out_valid_r;
  logic [7:0]  hdr_r, b1_r, b2_r, b3_r;
  logic [7:0]  hdr_nxt, b1_nxt, b2_nxt, b3_nxt;
  logic [13:0] bend_biased;
  logic        load;

  assign pop_ready   = !out_valid_r || out_ready;
  assign load        = pop_valid && pop_ready;
  assign bend_biased = pop_cmd.bend + BEND_OFFSET;

  always_comb begin
    if (pop_cmd.is_sysex) begin
      hdr_nxt = {CABLE_NUM, pop_cmd.cin};
      b1_nxt  = pop_cmd.b0;
      b2_nxt  = pop_cmd.b1;
      b3_nxt  = pop_cmd.b2;
    end else begin
      hdr_nxt = {CABLE_NUM, 1'b1, pop_cmd.kind};
      b1_nxt  = {1'b1, pop_cmd.kind, pop_cmd.chan};
      case (pop_cmd.kind)
        KIND_BEND: begin
          b2_nxt = {1'b0, bend_biased[6:0]};
          b3_nxt = {1'b0, bend_biased[13:7]};
        end
        KIND_PROGRAM, KIND_PRESSURE: begin
          b2_nxt = pop_cmd.b0 & DATA_MASK;
          b3_nxt = 8'h00;
        end
        default: begin
          b2_nxt = pop_cmd.b0 & DATA_MASK;
          b3_nxt = pop_cmd.b1 & DATA_MASK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hdr_r <= hdr_nxt;
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
      b3_r  <= b3_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_packet_header     = hdr_r;
  assign out_packet_byte_one   = b1_r;
  assign out_packet_byte_two   = b2_r;
  assign out_packet_byte_three = b3_r;

endmodule

// File: design/usb_midi_event_packet_encoder_top.sv
// Top level of the USB-MIDI event packet encoder (cable 0).
// Instantiates umepe_front, umepe_queue and umepe_back; uses umepe_pkg.
//
// One item is taken per clock while in_ready is high, and at most one 4-byte
// event packet leaves per clock. The front end classifies an item in the cycle
// it is taken and writes it into the two-entry command queue at that edge; the
// back end moves it into the output register once that register is free.
// in_ready drops only while the link is up and the command queue is full, even
// if the output packet is being taken. Channel messages give one packet each;
// sysex bytes are held until three are gathered or the end mark arrives. With
// cfg_wr_data low on the last write every transfer is taken and dropped, and
// the held sysex bytes stay as they are.
module usb_midi_event_packet_encoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [3:0]         in_channel,
  input  logic [7:0]         in_data_first,
  input  logic [7:0]         in_data_second,
  input  logic signed [13:0] in_bend_amount,
  input  logic               in_sysex_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_packet_header,
  output logic [7:0]         out_packet_byte_one,
  output logic [7:0]         out_packet_byte_two,
  output logic [7:0]         out_packet_byte_three
);
  import umepe_pkg::*;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  pkt_cmd_t   push_cmd, pop_cmd;
  fe_status_t fe_status;
  q_status_t  q_status;

  umepe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_channel     (in_channel),
    .in_data_first  (in_data_first),
    .in_data_second (in_data_second),
    .in_bend_amount (in_bend_amount),
    .in_sysex_end   (in_sysex_end),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd),
    .status         (fe_status)
  );

  umepe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .status     (q_status)
  );

  umepe_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .pop_valid             (pop_valid),
    .pop_ready             (pop_ready),
    .pop_cmd               (pop_cmd),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_packet_header     (out_packet_header),
    .out_packet_byte_one   (out_packet_byte_one),
    .out_packet_byte_two   (out_packet_byte_two),
    .out_packet_byte_three (out_packet_byte_three)
  );

  a_held_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    fe_status.held_cnt != 2'd3)
    else $error("sysex hold count out of range");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count <= Q_CNT_W'(Q_DEPTH))
    else $error("command queue overfilled");

  a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_status.count != '0))
    else $error("packet appeared without a queued command");

  a_unlinked_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !fe_status.link) |=> $stable(fe_status.held_cnt))
    else $error("dropped transfer changed sysex state");

endmodule

// File: sim/usb_midi_event_packet_encoder_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for usb_midi_event_packet_encoder_top: queue-fed driver,
// clocked monitor and an in-bench packet predictor. Depends on design/umepe_pkg.sv
// and the encoder RTL.
module usb_midi_event_packet_encoder_top_test;
  import umepe_pkg::*;

  localparam logic [2:0] KIND_NOTE_ON    = 3'd1;
  localparam logic [2:0] KIND_POLY_TOUCH = 3'd2;
  localparam logic [2:0] KIND_CONTROL    = 3'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         chan;
    logic [7:0]         d1;
    logic [7:0]         d2;
    logic signed [13:0] bend;
    logic               last;
  } midi_item_t;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] one;
    logic [7:0] two;
    logic [7:0] three;
  } usb_packet_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_req_type = '0;
  logic [3:0]         in_channel = '0;
  logic [7:0]         in_data_first = '0;
  logic [7:0]         in_data_second = '0;
  logic signed [13:0] in_bend_amount = '0;
  logic               in_sysex_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_packet_header;
  logic [7:0]         out_packet_byte_one;
  logic [7:0]         out_packet_byte_two;
  logic [7:0]         out_packet_byte_three;

  midi_item_t  pending_items[$];
  usb_packet_t expected_packets[$];

  // predictor state
  logic       link_on = 1'b0;
  logic [7:0] held_bytes[2];
  logic [1:0] held_count = 2'd0;

  logic in_fire = 1'b0;
  logic hold_off = 1'b0;
  int   accepted_in = 0;
  int   mismatch_count = 0;
  logic quiet;

  assign quiet = (accepted_in >= 250) && (accepted_in < 330);

  usb_midi_event_packet_encoder_top DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_channel            (in_channel),
    .in_data_first         (in_data_first),
    .in_data_second        (in_data_second),
    .in_bend_amount        (in_bend_amount),
    .in_sysex_end          (in_sysex_end),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_packet_header     (out_packet_header),
    .out_packet_byte_one   (out_packet_byte_one),
    .out_packet_byte_two   (out_packet_byte_two),
    .out_packet_byte_three (out_packet_byte_three)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH at %0t: %s got 0x%02h, want 0x%02h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic encode_midi_item(midi_item_t it);
    usb_packet_t pkt;
    logic [13:0] shifted;
    logic [7:0]  gathered[3];
    logic [1:0]  n;
    if (!link_on) return;
    if (it.kind != KIND_SYSEX) begin
      pkt.header = {CABLE_NUM, 1'b1, it.kind};
      pkt.one    = {1'b1, it.kind, it.chan};
      pkt.two    = it.d1 & DATA_MASK;
      pkt.three  = it.d2 & DATA_MASK;
      if (it.kind == KIND_BEND) begin
        shifted   = it.bend + BEND_OFFSET;
        pkt.two   = {1'b0, shifted[6:0]};
        pkt.three = {1'b0, shifted[13:7]};
      end else if (it.kind == KIND_PROGRAM || it.kind == KIND_PRESSURE) begin
        pkt.three = 8'h00;
      end
      expected_packets.push_back(pkt);
      return;
    end
    n = held_count;
    if (!it.last && n < SYSEX_HOLD_MAX) begin
      held_bytes[n] = it.d1;
      held_count = n + 2'd1;
      return;
    end
    gathered[0] = 8'h00;
    gathered[1] = 8'h00;
    gathered[2] = 8'h00;
    for (int i = 0; i < n; i++) gathered[i] = held_bytes[i];
    gathered[n] = it.d1;
    pkt.header = {CABLE_NUM, it.last ? CIN_SYSEX_CONT + 4'(n) + 4'd1 : CIN_SYSEX_CONT};
    pkt.one    = gathered[0];
    pkt.two    = gathered[1];
    pkt.three  = gathered[2];
    held_count = 2'd0;
    expected_packets.push_back(pkt);
  endtask

  // monitor and predictor
  always @(posedge clk) begin
    usb_packet_t want;
    midi_item_t  seen;
    in_fire = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_wr_en) link_on = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_packets.size() == 0) begin
          $display("MISMATCH at %0t: unexpected packet %02h %02h %02h %02h", $realtime,
                   out_packet_header, out_packet_byte_one, out_packet_byte_two,
                   out_packet_byte_three);
          mismatch_count++;
        end else begin
          want = expected_packets.pop_front();
          if (out_packet_header !== want.header)
            report_mismatch("header", out_packet_header, want.header);
          if (out_packet_byte_one !== want.one)
            report_mismatch("byte one", out_packet_byte_one, want.one);
          if (out_packet_byte_two !== want.two)
            report_mismatch("byte two", out_packet_byte_two, want.two);
          if (out_packet_byte_three !== want.three)
            report_mismatch("byte three", out_packet_byte_three, want.three);
        end
      end
      if (in_fire) begin
        seen = '{in_req_type, in_channel, in_data_first, in_data_second,
                 in_bend_amount, in_sysex_end};
        accepted_in++;
        encode_midi_item(seen);
      end
    end
  end

  // sender
  always @(negedge clk) begin
    midi_item_t it;
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_items.size() > 0 && (quiet || $urandom_range(0, 99) >= 18)) begin
        it = pending_items.pop_front();
        in_req_type    <= it.kind;
        in_channel     <= it.chan;
        in_data_first  <= it.d1;
        in_data_second <= it.d2;
        in_bend_amount <= it.bend;
        in_sysex_end   <= it.last;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    out_ready <= rst_n && !hold_off && (quiet || $urandom_range(0, 99) >= 18);
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    while (accepted_in < 120) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic midi_item_t mk_item(logic [2:0] kind, logic [3:0] chan, logic [7:0] d1,
                                         logic [7:0] d2, logic signed [13:0] bend,
                                         logic last);
    midi_item_t it;
    it = '{kind, chan, d1, d2, bend, last};
    return it;
  endfunction

  function automatic midi_item_t rand_item(logic [2:0] kind, logic last);
    return mk_item(kind, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)), last);
  endfunction

  task automatic queue_random_traffic(int n);
    int added;
    int len;
    int r;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          pending_items.push_back(rand_item(KIND_SYSEX, i == len - 1));
          if (i < len - 1 && $urandom_range(0, 9) == 0) begin
            pending_items.push_back(rand_item(3'($urandom_range(0, 6)), 1'($urandom_range(0, 1))));
            added++;
          end
        end
        added += len;
      end else if (r < 90) begin
        pending_items.push_back(rand_item(3'($urandom_range(0, 6)), 1'($urandom_range(0, 1))));
        added++;
      end else begin
        pending_items.push_back(rand_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
        added++;
      end
    end
  endtask

  task automatic drain_and_settle();
    while (pending_items.size() > 0 || in_valid || expected_packets.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_link(logic value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // unconfigured link: everything dropped
    pending_items.push_back(mk_item(KIND_NOTE_ON, 4'd3, 8'h40, 8'h7F, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'hF0, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'hF7, 8'h00, 14'sd0, 1'b1));
    pending_items.push_back(mk_item(KIND_BEND, 4'd9, 8'h00, 8'h00, 14'sd100, 1'b0));
    drain_and_settle();
    write_link(1'b1);

    pending_items.push_back(mk_item(KIND_NOTE_OFF, 4'd0, 8'h00, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_NOTE_ON, 4'd15, 8'hFF, 8'hFF, -14'sd1, 1'b1));
    pending_items.push_back(mk_item(KIND_POLY_TOUCH, 4'd5, 8'h80, 8'h7F, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_CONTROL, 4'd10, 8'h7F, 8'h80, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_PROGRAM, 4'd15, 8'hFF, 8'hFF, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_PRESSURE, 4'd0, 8'hAA, 8'h55, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_BEND, 4'd1, 8'hFF, 8'hFF, -14'sd8192, 1'b0));
    pending_items.push_back(mk_item(KIND_BEND, 4'd14, 8'h00, 8'h00, 14'sd8191, 1'b0));
    pending_items.push_back(mk_item(KIND_BEND, 4'd7, 8'h00, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_BEND, 4'd8, 8'h00, 8'h00, -14'sd1, 1'b0));
    // sysex endings with one, two and three bytes in the last packet
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'hFF, 8'h00, 14'sd0, 1'b1));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h00, 8'hFF, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h80, 8'h00, 14'sd0, 1'b1));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h01, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h7F, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'hFE, 8'h00, 14'sd0, 1'b1));
    // three bytes without an end mark
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'hF0, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h12, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h34, 8'h00, 14'sd0, 1'b0));
    // channel messages inside a running sysex stream
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h56, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_NOTE_ON, 4'd2, 8'h3C, 8'h64, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h78, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_BEND, 4'd4, 8'h00, 8'h00, 14'sd4096, 1'b1));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h9A, 8'h00, 14'sd0, 1'b1));

    queue_random_traffic(190);
    // leave two bytes held across the link going down
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'hF0, 8'h00, 14'sd0, 1'b1));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h11, 8'h00, 14'sd0, 1'b0));
    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h22, 8'h00, 14'sd0, 1'b0));
    drain_and_settle();
    write_link(1'b0);

    queue_random_traffic(40);
    drain_and_settle();
    write_link(1'b1);

    pending_items.push_back(mk_item(KIND_SYSEX, 4'd0, 8'h33, 8'h00, 14'sd0, 1'b1));
    queue_random_traffic(190);
    drain_and_settle();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TIMEOUT: transfers still outstanding");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
design/umepe_pkg.sv
design/umepe_front.sv
design/umepe_queue.sv
design/umepe_back.sv
design/usb_midi_event_packet_encoder_top.sv
sim/usb_midi_event_packet_encoder_top_test.sv
